/* rtl/xptw_pkg.sv */
// Shared types, constants and index/address helpers for the x86 page table walker.
// No dependencies; every other file of the block refers to this package by scoped name.
package xptw_pkg;

	localparam int PHYS_ADDR_BITS = 52;
	localparam int VA_HELD_BITS   = 48;
	localparam int IDX_BITS       = 10;
	localparam int FRAME_LSB      = 12;
	localparam int FIFO_DEPTH     = 2;
	localparam int FIFO_PTR_BITS  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] CFG_PAGING_ON   = 2'd0;
	localparam logic [1:0] CFG_TABLE_LEVELS = 2'd1;
	localparam logic [1:0] CFG_ROOT_ADDR   = 2'd2;

	localparam logic OUT_READ = 1'b0;
	localparam logic OUT_DONE = 1'b1;

	localparam logic REQ_TRANSLATE = 1'b0;

	localparam logic [2:0] LVL_1 = 3'd1;
	localparam logic [2:0] LVL_2 = 3'd2;
	localparam logic [2:0] LVL_3 = 3'd3;
	localparam logic [2:0] LVL_4 = 3'd4;

	typedef enum logic [1:0] {
		KIND_IDENT,
		KIND_WALK,
		KIND_RESP
	} item_kind_t;

	typedef struct packed {
		item_kind_t                kind;
		logic [63:0]               data;
		logic                      ok;
		logic [PHYS_ADDR_BITS-1:0] addr;
		logic [2:0]                levels;
	} walk_item_t;

	function automatic logic [IDX_BITS-1:0] walk_index(
		input logic [VA_HELD_BITS-1:0] hv,
		input logic [2:0]              lvl,
		input logic                    narrow
	);
		logic [IDX_BITS-1:0] idx;
		begin
			idx = '0;
			if (narrow) begin
				case (lvl)
					LVL_2: idx = hv[31:22];
					LVL_1: idx = hv[21:12];
					default: idx = '0;
				endcase
			end else begin
				case (lvl)
					LVL_4: idx = {1'b0, hv[47:39]};
					LVL_3: idx = {1'b0, hv[38:30]};
					LVL_2: idx = {1'b0, hv[29:21]};
					LVL_1: idx = {1'b0, hv[20:12]};
					default: idx = '0;
				endcase
			end
			return idx;
		end
	endfunction

	function automatic logic [PHYS_ADDR_BITS-1:0] entry_address(
		input logic [PHYS_ADDR_BITS-1:0] base,
		input logic [IDX_BITS-1:0]       idx,
		input logic                      narrow
	);
		logic [IDX_BITS+2:0] offset;
		begin
			offset = narrow ? {1'b0, idx, 2'b00} : {idx, 3'b000};
			return base + PHYS_ADDR_BITS'(offset);
		end
	endfunction

endpackage

/* rtl/x86_page_table_walker_core.sv */
// Top level of the x86 page table walker: front end, item queue and back end.
// Depends on xptw_pkg, xptw_front, xptw_fifo and xptw_back.
//
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   req_type, virt_addr, read_data, read_ok
// out      from block out_valid / out_stall out_kind, entry_addr, entry_is_wide,
//                                           frame_number, fault
// cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle unless out_stall holds it; items are queued, results registered.
// The back end's walk state update (one add for the next entry address) sets the rate.
// Reset clears the walk state, the queue and the output valid flag; config resets to
// paging off, two levels and a zero root. cfg_ready is always high.
// A stalled output holds its result while the two-entry queue takes further items;
// in_stall rises only when the queue is full.
module x86_page_table_walker_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [xptw_pkg::PHYS_ADDR_BITS-1:0] cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic [63:0]                         virt_addr,
	input  logic [63:0]                         read_data,
	input  logic                                read_ok,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                out_kind,
	output logic [xptw_pkg::PHYS_ADDR_BITS-1:0] entry_addr,
	output logic                                entry_is_wide,
	output logic [xptw_pkg::PHYS_ADDR_BITS-1:0] frame_number,
	output logic                                fault
);

	xptw_pkg::walk_item_t push_item;
	xptw_pkg::walk_item_t head_item;
	logic                 push;
	logic                 pop;
	logic                 queue_full;
	logic                 queue_empty;

	xptw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg_ready  (cfg_ready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.virt_addr  (virt_addr),
		.read_data  (read_data),
		.read_ok    (read_ok),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	xptw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.empty     (queue_empty),
		.full      (queue_full)
	);

	xptw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_item     (head_item),
		.queue_empty   (queue_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_kind      (out_kind),
		.entry_addr    (entry_addr),
		.entry_is_wide (entry_is_wide),
		.frame_number  (frame_number),
		.fault         (fault)
	);

endmodule

/* rtl/xptw_fifo.sv */
// Short item queue between the walker front and back ends.
// Depends on xptw_pkg for the item type and queue depth.
module xptw_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  xptw_pkg::walk_item_t push_item,
	input  logic                 pop,
	output xptw_pkg::walk_item_t head_item,
	output logic                 empty,
	output logic                 full
);

	xptw_pkg::walk_item_t entries_q [xptw_pkg::FIFO_DEPTH];
	logic [xptw_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [xptw_pkg::FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [xptw_pkg::FIFO_CNT_BITS-1:0] count_q;

	assign empty     = (count_q == '0);
	assign full      = (count_q == xptw_pkg::FIFO_CNT_BITS'(xptw_pkg::FIFO_DEPTH));
	assign head_item = entries_q[rd_ptr_q];

	function automatic logic [xptw_pkg::FIFO_PTR_BITS-1:0] ptr_next(
		input logic [xptw_pkg::FIFO_PTR_BITS-1:0] p
	);
		return (p == xptw_pkg::FIFO_PTR_BITS'(xptw_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop && !empty) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push && !full, pop && !empty})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/xptw_front.sv */
// Front end of the walker: configuration registers, input acceptance and item classification.
// Translate requests get their root entry address here; depends on xptw_pkg.
module xptw_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [1:0]                          cfg_index,
	input  logic [xptw_pkg::PHYS_ADDR_BITS-1:0] cfg_data,
	output logic                                cfg_ready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic [63:0]                         virt_addr,
	input  logic [63:0]                         read_data,
	input  logic                                read_ok,
	input  logic                                queue_full,
	output logic                                push,
	output xptw_pkg::walk_item_t                push_item
);

	logic                                paging_on_q;
	logic [2:0]                          table_levels_q;
	logic [xptw_pkg::PHYS_ADDR_BITS-1:0] root_addr_q;

	logic [2:0]                            lv;
	logic                                  narrow;
	logic [xptw_pkg::PHYS_ADDR_BITS-1:0]   root_base;
	logic [xptw_pkg::VA_HELD_BITS-1:0]     hv;

	assign cfg_ready = 1'b1;
	assign in_stall  = queue_full;
	assign push      = in_valid && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_on_q    <= 1'b0;
			table_levels_q <= xptw_pkg::LVL_2;
			root_addr_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				xptw_pkg::CFG_PAGING_ON:    paging_on_q    <= cfg_data[0];
				xptw_pkg::CFG_TABLE_LEVELS: table_levels_q <= cfg_data[2:0];
				xptw_pkg::CFG_ROOT_ADDR:    root_addr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (table_levels_q == xptw_pkg::LVL_4) begin
			lv = xptw_pkg::LVL_4;
		end else if (table_levels_q == xptw_pkg::LVL_3) begin
			lv = xptw_pkg::LVL_3;
		end else begin
			lv = xptw_pkg::LVL_2;
		end
		narrow    = (lv == xptw_pkg::LVL_2);
		root_base = (lv == xptw_pkg::LVL_3) ? {root_addr_q[xptw_pkg::PHYS_ADDR_BITS-1:5], 5'b0}
			: {root_addr_q[xptw_pkg::PHYS_ADDR_BITS-1:12], 12'b0};
		hv = (lv == xptw_pkg::LVL_4) ? virt_addr[xptw_pkg::VA_HELD_BITS-1:0]
			: {16'b0, virt_addr[31:0]};

		push_item.data   = (req_type == xptw_pkg::REQ_TRANSLATE) ? virt_addr : read_data;
		push_item.ok     = read_ok;
		push_item.levels = lv;
		push_item.addr   = xptw_pkg::entry_address(root_base,
			xptw_pkg::walk_index(hv, lv, narrow), narrow);
		if (req_type != xptw_pkg::REQ_TRANSLATE) begin
			push_item.kind = xptw_pkg::KIND_RESP;
		end else if (paging_on_q) begin
			push_item.kind = xptw_pkg::KIND_WALK;
		end else begin
			push_item.kind = xptw_pkg::KIND_IDENT;
		end
	end

endmodule

/* rtl/xptw_back.sv */
// Back end of the walker: walk state, next entry address, finish and fault results.
// Holds the output register; depends on xptw_pkg for the item type and helpers.
module xptw_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  xptw_pkg::walk_item_t                head_item,
	input  logic                                queue_empty,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                out_kind,
	output logic [xptw_pkg::PHYS_ADDR_BITS-1:0] entry_addr,
	output logic                                entry_is_wide,
	output logic [xptw_pkg::PHYS_ADDR_BITS-1:0] frame_number,
	output logic                                fault
);

	logic                                busy_q;
	logic [2:0]                          level_q;
	logic                                narrow_q;
	logic [xptw_pkg::VA_HELD_BITS-1:0]   held_virt_q;

	logic                                out_valid_q;
	logic                                out_kind_q;
	logic [xptw_pkg::PHYS_ADDR_BITS-1:0] entry_addr_q;
	logic                                entry_is_wide_q;
	logic [xptw_pkg::PHYS_ADDR_BITS-1:0] frame_number_q;
	logic                                fault_q;

	logic                                busy_n;
	logic [2:0]                          level_n;
	logic                                narrow_n;
	logic [xptw_pkg::VA_HELD_BITS-1:0]   held_virt_n;
	logic                                res_valid;
	logic                                res_kind;
	logic [xptw_pkg::PHYS_ADDR_BITS-1:0] res_addr;
	logic                                res_wide;
	logic [xptw_pkg::PHYS_ADDR_BITS-1:0] res_frame;
	logic                                res_fault;
	logic [63:0]                         pte;
	logic [2:0]                          level_dec;
	logic                                load_out;

	assign pop      = !queue_empty && (!out_valid_q || !out_stall);
	assign load_out = pop && res_valid;

	always_comb begin
		busy_n      = busy_q;
		level_n     = level_q;
		narrow_n    = narrow_q;
		held_virt_n = held_virt_q;
		res_valid   = 1'b0;
		res_kind    = xptw_pkg::OUT_DONE;
		res_addr    = '0;
		res_wide    = 1'b0;
		res_frame   = '0;
		res_fault   = 1'b0;
		pte         = narrow_q ? {32'b0, head_item.data[31:0]} : head_item.data;
		level_dec   = level_q - 1'b1;
		case (head_item.kind)
			xptw_pkg::KIND_IDENT: begin
				res_valid = 1'b1;
				res_frame = head_item.data[63:xptw_pkg::FRAME_LSB];
				busy_n    = 1'b0;
			end
			xptw_pkg::KIND_WALK: begin
				res_valid   = 1'b1;
				res_kind    = xptw_pkg::OUT_READ;
				res_addr    = head_item.addr;
				res_wide    = (head_item.levels != xptw_pkg::LVL_2);
				busy_n      = 1'b1;
				level_n     = head_item.levels;
				narrow_n    = (head_item.levels == xptw_pkg::LVL_2);
				held_virt_n = (head_item.levels == xptw_pkg::LVL_4)
					? head_item.data[xptw_pkg::VA_HELD_BITS-1:0]
					: {16'b0, head_item.data[31:0]};
			end
			xptw_pkg::KIND_RESP: begin
				if (busy_q) begin
					res_valid = 1'b1;
					if (!head_item.ok || !pte[0]) begin
						res_fault = 1'b1;
						busy_n    = 1'b0;
					end else if (level_q == xptw_pkg::LVL_2 && pte[7]) begin
						busy_n    = 1'b0;
						res_frame = narrow_q
							? xptw_pkg::PHYS_ADDR_BITS'({pte[51:22], held_virt_q[21:12]})
							: xptw_pkg::PHYS_ADDR_BITS'({pte[51:21], held_virt_q[20:12]});
					end else if (level_q <= xptw_pkg::LVL_1) begin
						busy_n    = 1'b0;
						res_frame = xptw_pkg::PHYS_ADDR_BITS'(pte[51:12]);
					end else begin
						res_kind = xptw_pkg::OUT_READ;
						level_n  = level_dec;
						res_wide = !narrow_q;
						res_addr = xptw_pkg::entry_address({pte[51:12], 12'b0},
							xptw_pkg::walk_index(held_virt_q, level_dec, narrow_q), narrow_q);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			level_q     <= '0;
			narrow_q    <= 1'b0;
			held_virt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q      <= busy_n;
				level_q     <= level_n;
				narrow_q    <= narrow_n;
				held_virt_q <= held_virt_n;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kind_q      <= res_kind;
			entry_addr_q    <= res_addr;
			entry_is_wide_q <= res_wide;
			frame_number_q  <= res_frame;
			fault_q         <= res_fault;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_kind      = out_kind_q;
	assign entry_addr    = entry_addr_q;
	assign entry_is_wide = entry_is_wide_q;
	assign frame_number  = frame_number_q;
	assign fault         = fault_q;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (level_q >= xptw_pkg::LVL_1 && level_q <= xptw_pkg::LVL_4))
		else $error("walk level out of range while busy");

	a_narrow_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && narrow_q) |-> (level_q <= xptw_pkg::LVL_2))
		else $error("two-level walk with level above two");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("loaded result not presented");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == xptw_pkg::OUT_READ) |-> (!fault_q && frame_number_q == '0))
		else $error("read request carries frame or fault");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == xptw_pkg::OUT_DONE) |-> (!entry_is_wide_q && entry_addr_q == '0))
		else $error("finished item carries an entry address");

endmodule
